// File: hw/rtl/ring_walk_visit_tracker_defines.svh
// Assertion macros for the ring walk visit tracker.
// Included by the top level; no other dependencies.
`ifndef RING_WALK_VISIT_TRACKER_DEFINES_SVH
`define RING_WALK_VISIT_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RWVT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rwvt assertion failed");
`define RWVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rwvt assertion failed");
`else
`define RWVT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RWVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/rwvt_pkg.sv
// Shared types and constants of the ring walk visit tracker.
// No dependencies.
package rwvt_pkg;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_STEP  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
	localparam logic [10:0] DISTINCT_MAX = 11'h7FF;

	typedef struct packed {
		logic        error;
		logic [10:0] distinct_sites;
		logic        discovered;
		logic [31:0] visits;
		logic [31:0] steps_taken;
		logic [9:0]  position;
	} out_item_t;

endpackage

// File: hw/rtl/ring_walk_visit_tracker.sv
// Walker on a ring of sites with a per-site visit count store.
// A read, step or ignored item is read from memory at transfer; once the output slot is free the
// result is registered, with the write-back for a step, and no new item is taken before that. A
// step from a position past a shrunk ring first goes through the remainder unit. A valid start
// clears the whole store one entry per cycle. After reset the same clearing pass runs with no
// input transfer taken; configuration anytime.
`include "ring_walk_visit_tracker_defines.svh"

module ring_walk_visit_tracker #(
	parameter int MAX_SITES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,     // ring_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,      // direction, site[10:1], zero fill
	input  logic [1:0]  s_tuser,      // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata       // position, steps_taken, visits, discovered,
	                                  // distinct_sites, error, zero fill
);

	localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
	localparam int EW = $clog2(MAX_SITES + 1);
	localparam int VW = AW + 1;
	localparam int RESET_EFF = (1024 > MAX_SITES) ? MAX_SITES : 1024;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_WRAP   = 2'd1;
	localparam logic [1:0] ST_ACCESS = 2'd2;
	localparam logic [1:0] ST_CLEAR  = 2'd3;

	logic [1:0]    state_q, state_d;
	logic [1:0]    op_q, op_d;
	logic [AW-1:0] addr_q, addr_d;
	logic [AW-1:0] clr_q;
	logic          err_q, err_d;
	logic          zero_q, zero_d;
	logic          rd_d, wrap_go;
	logic [EW-1:0] eff_q;
	logic [AW-1:0] pos_q;
	logic [31:0]   steps_q;
	logic [10:0]   distinct_q;
	logic          m_tvalid_q;
	rwvt_pkg::out_item_t out_q, out_d;

	logic          accept, slot_free;
	logic [9:0]    site;
	logic          dir;
	logic [31:0]   site32, eff32, pos32, v32, cfg32, eff_new;
	logic [AW-1:0] np;
	logic          fast;
	logic          wrap_done;
	logic [EW-1:0] wrap_res;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [31:0]   wr_data, rd_data, cnt_inc;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {1'b0, out_q};

	assign dir    = s_tdata[0];
	assign site   = s_tdata[10:1];
	assign site32 = 32'(site);
	assign eff32  = 32'(eff_q);
	assign pos32  = 32'(pos_q);
	assign v32    = dir ? (pos32 - 32'd1) : (pos32 + 32'd1);

	assign cfg32   = 32'(cfg_data);
	assign eff_new = (cfg32 == 32'd0) ? 32'd1 :
	                 (cfg32 > 32'(MAX_SITES)) ? 32'(MAX_SITES) : cfg32;

	always_comb begin
		fast = 1'b1;
		np   = AW'(v32);
		if (dir && pos_q == '0) begin
			np = AW'(eff32 - 32'd1);
		end else if (v32 < eff32) begin
			np = AW'(v32);
		end else if (v32 < (eff32 << 1)) begin
			np = AW'(v32 - eff32);
		end else begin
			fast = 1'b0;
		end
	end

	always_comb begin
		op_d    = rwvt_pkg::OP_READ;
		addr_d  = pos_q;
		err_d   = 1'b0;
		zero_d  = 1'b0;
		rd_d    = 1'b1;
		wrap_go = 1'b0;
		state_d = ST_ACCESS;
		unique case (s_tuser)
			rwvt_pkg::MODE_START: begin
				if (site32 >= eff32) begin
					err_d = 1'b1;
				end else begin
					op_d    = rwvt_pkg::OP_START;
					addr_d  = AW'(site32);
					rd_d    = 1'b0;
					state_d = ST_CLEAR;
				end
			end
			rwvt_pkg::MODE_STEP: begin
				op_d = rwvt_pkg::OP_STEP;
				if (fast) begin
					addr_d = np;
				end else begin
					rd_d    = 1'b0;
					wrap_go = 1'b1;
					state_d = ST_WRAP;
				end
			end
			rwvt_pkg::MODE_READ: begin
				zero_d = (site32 >= 32'(MAX_SITES));
				addr_d = zero_d ? '0 : AW'(site32);
			end
			default: begin
			end
		endcase
	end

	rwvt_wrap #(
		.VW(VW),
		.DW(EW)
	) u_wrap (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && wrap_go),
		.value   (VW'(v32)),
		.modulus (eff_q),
		.done    (wrap_done),
		.result  (wrap_res)
	);

	assign rd_en   = (accept && rd_d) || (state_q == ST_WRAP && wrap_done);
	assign rd_addr = (state_q == ST_WRAP) ? AW'(wrap_res) : addr_d;

	assign cnt_inc = (rd_data != rwvt_pkg::COUNT_MAX) ? rd_data + 32'd1 : rd_data;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = cnt_inc;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = (op_q == rwvt_pkg::OP_START && clr_q == addr_q) ? 32'd1 : 32'd0;
		end else if (state_q == ST_ACCESS && slot_free && op_q == rwvt_pkg::OP_STEP) begin
			wr_en = 1'b1;
		end
	end

	rwvt_ram #(
		.WIDTH(32),
		.DEPTH(MAX_SITES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		out_d.position       = 10'(pos32);
		out_d.steps_taken    = steps_q;
		out_d.visits         = zero_q ? 32'd0 : rd_data;
		out_d.discovered     = 1'b0;
		out_d.distinct_sites = distinct_q;
		out_d.error          = err_q;
		case (op_q)
			rwvt_pkg::OP_START: begin
				out_d.position       = 10'(32'(addr_q));
				out_d.steps_taken    = 32'd0;
				out_d.visits         = 32'd1;
				out_d.distinct_sites = 11'd1;
			end
			rwvt_pkg::OP_STEP: begin
				out_d.position    = 10'(32'(addr_q));
				out_d.steps_taken = (steps_q != rwvt_pkg::COUNT_MAX) ? steps_q + 32'd1 : steps_q;
				out_d.visits      = cnt_inc;
				out_d.discovered  = (rd_data == 32'd0);
				if (rd_data == 32'd0 && distinct_q != rwvt_pkg::DISTINCT_MAX) begin
					out_d.distinct_sites = distinct_q + 11'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			op_q       <= rwvt_pkg::OP_INIT;
			clr_q      <= '0;
			eff_q      <= EW'(RESET_EFF);
			pos_q      <= '0;
			steps_q    <= '0;
			distinct_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				eff_q <= EW'(eff_new);
			end
			if (state_q == ST_ACCESS && slot_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= op_d;
						state_q <= state_d;
					end
				end
				ST_WRAP: begin
					if (wrap_done) begin
						state_q <= ST_ACCESS;
					end
				end
				ST_ACCESS: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
						if (op_q == rwvt_pkg::OP_START || op_q == rwvt_pkg::OP_STEP) begin
							pos_q      <= addr_q;
							steps_q    <= out_d.steps_taken;
							distinct_q <= out_d.distinct_sites;
						end
					end
				end
				ST_CLEAR: begin
					if (clr_q == AW'(MAX_SITES - 1)) begin
						clr_q   <= '0;
						state_q <= (op_q == rwvt_pkg::OP_START) ? ST_ACCESS : ST_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= addr_d;
			err_q  <= err_d;
			zero_q <= zero_d;
		end else if (state_q == ST_WRAP && wrap_done) begin
			addr_q <= AW'(wrap_res);
		end
		if (state_q == ST_ACCESS && slot_free) begin
			out_q <= out_d;
		end
	end

	`RWVT_ASSERT_IMPLY(a_no_transfer_in_clear, clk, arst_n, state_q == ST_CLEAR, !s_tready)
	`RWVT_ASSERT_NEXT(a_transfer_goes_busy, clk, arst_n, s_tvalid && s_tready, state_q != ST_IDLE)
	`RWVT_ASSERT_IMPLY(a_distinct_bound, clk, arst_n, 1'b1, 32'(distinct_q) <= 32'(MAX_SITES))
	`RWVT_ASSERT_IMPLY(a_write_state, clk, arst_n, wr_en, state_q == ST_ACCESS || state_q == ST_CLEAR)

endmodule

// File: hw/rtl/rwvt_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module rwvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/rwvt_wrap.sv
// Iterative remainder unit that folds a position back onto the ring, one bit per cycle.
// No dependencies.
module rwvt_wrap #(
	parameter int VW = 11,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [VW-1:0] value,
	input  logic [DW-1:0] modulus,
	output logic          done,
	output logic [DW-1:0] result
);

	localparam int CW = $clog2(VW + 1);

	logic [VW-1:0] val_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] mod_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {rem_q, val_q[VW-1]};
	assign diff  = trial - {1'b0, mod_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
			mod_q <= modulus;
		end else if (busy_q) begin
			val_q <= val_q << 1;
			if (trial >= {1'b0, mod_q}) begin
				rem_q <= diff[DW-1:0];
			end else begin
				rem_q <= trial[DW-1:0];
			end
		end
	end

	assign done   = done_q;
	assign result = rem_q;

endmodule
